/* rtl/core/pidfd_pkg.sv */
// shared types, constants and helper functions for the pid controller
`default_nettype none
package pidfd_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int MulWidth  = 2 * DataWidth;
  localparam int AccWidth  = DataWidth + 3;

  localparam logic signed [DataWidth-1:0] SMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] SMin = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic signed [DataWidth-1:0] Alpha =
    DataWidth'(((64'd1 << FracBits) * 2 + 5) / 10);
  localparam logic signed [DataWidth-1:0] OneQ = DataWidth'(64'd1 << FracBits);

  localparam int DivSteps = DataWidth + FracBits;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  localparam int CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    RegPropGain   = 3'd0,
    RegIntegGain  = 3'd1,
    RegDerivGain  = 3'd2,
    RegTimeStep   = 3'd3,
    RegOutputLow  = 3'd4,
    RegOutputHigh = 3'd5,
    RegIntegLimit = 3'd6,
    RegFeedfwd    = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    CmdUpdate = 1'b0,
    CmdClear  = 1'b1
  } cmd_e;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MulInc,
    MulAlpha,
    MulProp,
    MulInteg,
    MulDeriv,
    MulFeed
  } mul_sel_e;

  typedef enum logic [3:0] {
    StIdle,
    StErr,
    StInc,
    StIntLim,
    StDivStart,
    StDiv,
    StAlpha,
    StSmooth,
    StProp,
    StInteg,
    StDeriv,
    StFeed,
    StFinal,
    StOut
  } state_e;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     calc_err;
    logic     mul_go;
    mul_sel_e mul_sel;
    logic     do_inc;
    logic     div_start;
    logic     div_step;
    logic     do_smooth;
    logic     acc_clr;
    logic     acc_add;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic deriv_en;
    logic div_done;
  } dp_status_t;

  function automatic logic signed [DataWidth-1:0] sat_wide(
    input logic signed [AccWidth-1:0] x
  );
    logic signed [AccWidth-1:0] hi;
    logic signed [AccWidth-1:0] lo;
    begin
      hi = AccWidth'(SMax);
      lo = AccWidth'(SMin);
      if (x > hi) sat_wide = SMax;
      else if (x < lo) sat_wide = SMin;
      else sat_wide = x[DataWidth-1:0];
    end
  endfunction

  // q product from full signed product magnitude handling
  function automatic logic signed [DataWidth-1:0] q_scale(
    input logic [MulWidth-1:0] pmag,
    input logic                neg
  );
    logic [MulWidth-1:0] m;
    logic [MulWidth-1:0] lim;
    begin
      m   = pmag >> FracBits;
      lim = neg ? MulWidth'(SMax) + MulWidth'(1) : MulWidth'(SMax);
      if (m > lim) m = lim;
      q_scale = neg ? DataWidth'(-m) : DataWidth'(m);
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/core/pidfd_ctrl.sv */
// sequencer for one controller item
`default_nettype none
module pidfd_ctrl import pidfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       command_i,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid = out_valid_q;
  assign in_ready  = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.mul_sel = MulInc;
    if (out_valid_q && out_ready) out_valid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid) begin
          if (command_i == CmdClear) begin
            cmd_o.clear = 1'b1;
            state_d = StOut;
          end else begin
            cmd_o.load = 1'b1;
            state_d = StErr;
          end
        end
      end
      StErr: begin
        cmd_o.calc_err = 1'b1;
        state_d = StInc;
      end
      StInc: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.mul_sel = MulInc;
        state_d = StIntLim;
      end
      StIntLim: begin
        cmd_o.do_inc = 1'b1;
        state_d = status_i.deriv_en ? StDivStart : StProp;
      end
      StDivStart: begin
        cmd_o.div_start = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) state_d = StAlpha;
      end
      StAlpha: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.mul_sel = MulAlpha;
        state_d = StSmooth;
      end
      StSmooth: begin
        cmd_o.do_smooth = 1'b1;
        state_d = StProp;
      end
      StProp: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.mul_sel = MulProp;
        cmd_o.acc_clr = 1'b1;
        state_d = StInteg;
      end
      StInteg: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.mul_sel = MulInteg;
        cmd_o.acc_add = 1'b1;
        state_d = StDeriv;
      end
      StDeriv: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.mul_sel = MulDeriv;
        cmd_o.acc_add = 1'b1;
        state_d = StFeed;
      end
      StFeed: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.mul_sel = MulFeed;
        cmd_o.acc_add = 1'b1;
        state_d = StFinal;
      end
      StFinal: begin
        cmd_o.acc_add = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        // wait for a free output register
        if (!out_valid_q || out_ready) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("took a second item while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid)
    else $error("finished item not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule
`default_nettype wire

/* rtl/core/pidfd_dp.sv */
// datapath: shared multiplier, restoring divider, integral and filter state
`default_nettype none
module pidfd_dp import pidfd_pkg::*; (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dp_cmd_t                     cmd_i,
  output dp_status_t                       status_o,
  input  wire logic signed [DataWidth-1:0] target_i,
  input  wire logic signed [DataWidth-1:0] measured_i,
  input  wire logic signed [DataWidth-1:0] prop_gain_i,
  input  wire logic signed [DataWidth-1:0] integ_gain_i,
  input  wire logic signed [DataWidth-1:0] deriv_gain_i,
  input  wire logic [DataWidth-2:0]        time_step_i,
  input  wire logic signed [DataWidth-1:0] output_low_i,
  input  wire logic signed [DataWidth-1:0] output_high_i,
  input  wire logic [DataWidth-2:0]        integ_limit_i,
  input  wire logic signed [DataWidth-1:0] feedfwd_gain_i,
  output logic signed [DataWidth-1:0]      drive_o,
  output logic                             saturated_o
);

  localparam int DivW = DataWidth + FracBits;

  logic signed [DataWidth-1:0] tgt_q, meas_q, err_q, inc_q, prod_q;
  logic signed [DataWidth-1:0] integ_q, last_q, dsm_q, dval_q;
  logic                        have_q;
  logic signed [DataWidth-1:0] sum_q;
  logic signed [AccWidth-1:0]  acc_q;
  logic signed [DataWidth-1:0] drive_q;
  logic                        sat_q;

  // divider
  logic [DivW-1:0]     rem_q;
  logic [DivW-1:0]     quo_q;
  logic [DivW-1:0]     num_q;
  logic                dneg_q;
  logic [DivCntW-1:0]  dcnt_q;
  logic signed [DataWidth-1:0] raw_d;

  // multiplier operands
  logic signed [DataWidth-1:0] ma, mb;
  logic [MulWidth-1:0]         pmag;
  logic [DataWidth-1:0]        am, bm;
  logic                        pneg;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MulInc:   begin ma = err_q;          mb = {1'b0, time_step_i}; end
      MulAlpha: begin ma = Alpha;          mb = sat_wide(AccWidth'(raw_d) - AccWidth'(dsm_q)); end
      MulProp:  begin ma = prop_gain_i;    mb = err_q;   end
      MulInteg: begin ma = integ_gain_i;   mb = integ_q; end
      MulDeriv: begin ma = deriv_gain_i;   mb = dval_q;  end
      MulFeed:  begin ma = feedfwd_gain_i; mb = tgt_q;   end
      default:  begin ma = '0;             mb = '0;      end
    endcase
    am   = ma[DataWidth-1] ? DataWidth'(-ma) : ma;
    bm   = mb[DataWidth-1] ? DataWidth'(-mb) : mb;
    pneg = ma[DataWidth-1] ^ mb[DataWidth-1];
    pmag = MulWidth'(am) * MulWidth'(bm);
  end

  // quotient saturate with sign
  always_comb begin
    logic [DivW-1:0] lim;
    lim = dneg_q ? DivW'(SMax) + DivW'(1) : DivW'(SMax);
    if (quo_q > lim) raw_d = dneg_q ? SMin : SMax;
    else raw_d = dneg_q ? DataWidth'(-quo_q) : DataWidth'(quo_q);
  end

  logic signed [DataWidth-1:0] ilim_pos, ilim_neg, int_sum;
  logic signed [DataWidth-1:0] dm, ndm;
  logic [DivW-1:0]             trial;

  always_comb begin
    ilim_pos = {1'b0, integ_limit_i};
    ilim_neg = DataWidth'(-ilim_pos);
    // the increment is still in the product register here
    int_sum  = sat_wide(AccWidth'(integ_q) + AccWidth'(prod_q));
    if (int_sum > ilim_pos) int_sum = ilim_pos;
    if (int_sum < ilim_neg) int_sum = ilim_neg;
    dm  = sat_wide(AccWidth'(meas_q) - AccWidth'(last_q));
    ndm = sat_wide(-AccWidth'(dm));
    trial = {rem_q[DivW-2:0], num_q[DivW-1]};
  end

  assign status_o.deriv_en = (time_step_i != '0) && have_q;
  assign status_o.div_done = (dcnt_q == DivCntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      last_q  <= '0;
      dsm_q   <= '0;
      have_q  <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      if (cmd_i.clear) begin
        integ_q <= '0;
        last_q  <= '0;
        dsm_q   <= '0;
        have_q  <= 1'b0;
      end
      if (cmd_i.do_inc) begin
        integ_q <= int_sum;
      end
      // previous sample is replaced only once the derivative has used it
      if (cmd_i.acc_clr) begin
        last_q  <= meas_q;
        have_q  <= 1'b1;
      end
      if (cmd_i.do_smooth) begin
        dsm_q <= sat_wide(AccWidth'(dsm_q) + AccWidth'(prod_q));
      end
      if (cmd_i.finish && !cmd_i.clear && sat_q && integ_gain_i > 0 &&
          ((drive_q == output_high_i && sum_q > output_high_i && err_q > 0) ||
           (sum_q <= output_high_i && err_q < 0))) begin
        integ_q <= sat_wide(AccWidth'(integ_q) - AccWidth'(inc_q));
      end
      if (cmd_i.div_start) dcnt_q <= DivCntW'(DivSteps);
      else if (cmd_i.div_step && dcnt_q != '0) dcnt_q <= dcnt_q - DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tgt_q  <= target_i;
      meas_q <= measured_i;
      dval_q <= '0;
    end
    if (cmd_i.calc_err) err_q <= sat_wide(AccWidth'(tgt_q) - AccWidth'(meas_q));
    if (cmd_i.mul_go) prod_q <= q_scale(pmag, pneg);
    if (cmd_i.do_inc) inc_q <= prod_q;
    if (cmd_i.div_start) begin
      dneg_q <= ndm[DataWidth-1];
      num_q  <= DivW'(ndm[DataWidth-1] ? DataWidth'(-ndm) : ndm) << FracBits;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      num_q <= num_q << 1;
      if (trial >= DivW'(time_step_i)) begin
        rem_q <= trial - DivW'(time_step_i);
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
    if (cmd_i.do_smooth) dval_q <= sat_wide(AccWidth'(dsm_q) + AccWidth'(prod_q));
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (cmd_i.acc_add) acc_q <= acc_q + AccWidth'(prod_q);
    if (cmd_i.acc_add && !cmd_i.mul_go) begin
      sum_q <= sat_wide(acc_q + AccWidth'(prod_q));
    end
    if (cmd_i.clear) begin
      drive_q <= '0;
      sat_q   <= 1'b0;
      sum_q   <= '0;
    end else if (cmd_i.acc_add && !cmd_i.mul_go) begin
      // clamp, high test first
      if (sat_wide(acc_q + AccWidth'(prod_q)) > output_high_i) begin
        drive_q <= output_high_i;
        sat_q   <= 1'b1;
      end else if (sat_wide(acc_q + AccWidth'(prod_q)) < output_low_i) begin
        drive_q <= output_low_i;
        sat_q   <= 1'b1;
      end else begin
        drive_q <= sat_wide(acc_q + AccWidth'(prod_q));
        sat_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      drive_o     <= drive_q;
      saturated_o <= sat_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> dcnt_q == DivCntW'(DivSteps))
    else $error("divider count not loaded");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> !have_q && integ_q == '0)
    else $error("clear left state behind");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc_clr |=> have_q)
    else $error("sample not recorded");

endmodule
`default_nettype wire

/* rtl/core/pid_filtered_deriv_antiwindup.sv */
// top level of the fixed-point pid controller
// Fixed-point Q16.16 PID controller with derivative on measurement, low-pass
// smoothed derivative and conditional-integration anti-windup. One item at a
// time: an update item with the derivative path active runs the 48-step
// restoring divider for -(delta measured)/time_step. A single 32x32
// multiplier is shared by the six products. Configuration must be written
// through the cfg port only while the block is idle; the block itself does
// not enforce this.
`default_nettype none
module pid_filtered_deriv_antiwindup import pidfd_pkg::*; (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        command_i,
  input  wire logic signed [DataWidth-1:0] target_i,
  input  wire logic signed [DataWidth-1:0] measured_i,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [DataWidth-1:0]      drive_o,
  output logic                             saturated_o,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CfgIdxW-1:0]          cfg_index,
  input  wire logic [DataWidth-1:0]        cfg_data
);

  logic signed [DataWidth-1:0] prop_q, integ_q, deriv_q, low_q, high_q, ff_q;
  logic [DataWidth-2:0]        ts_q, ilim_q;
  dp_cmd_t                     cmd;
  dp_status_t                  status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q  <= '0;
      integ_q <= '0;
      deriv_q <= '0;
      ts_q    <= '0;
      low_q   <= -OneQ;
      high_q  <= OneQ;
      ilim_q  <= OneQ[DataWidth-2:0];
      ff_q    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        RegPropGain:   prop_q  <= cfg_data;
        RegIntegGain:  integ_q <= cfg_data;
        RegDerivGain:  deriv_q <= cfg_data;
        RegTimeStep:   ts_q    <= cfg_data[DataWidth-2:0];
        RegOutputLow:  low_q   <= cfg_data;
        RegOutputHigh: high_q  <= cfg_data;
        RegIntegLimit: ilim_q  <= cfg_data[DataWidth-2:0];
        RegFeedfwd:    ff_q    <= cfg_data;
        default: ;
      endcase
    end
  end

  pidfd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command_i (command_i),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  pidfd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .target_i       (target_i),
    .measured_i     (measured_i),
    .prop_gain_i    (prop_q),
    .integ_gain_i   (integ_q),
    .deriv_gain_i   (deriv_q),
    .time_step_i    (ts_q),
    .output_low_i   (low_q),
    .output_high_i  (high_q),
    .integ_limit_i  (ilim_q),
    .feedfwd_gain_i (ff_q),
    .drive_o        (drive_o),
    .saturated_o    (saturated_o)
  );

endmodule
`default_nettype wire
